[hdl/sdp_pkg.sv]
// Shared constants and helpers for the stepper dial positioner.
package sdp_pkg;

   // Dial geometry
   localparam int DIAL_POSITIONS = 12;
   localparam int HALF_DIAL      = DIAL_POSITIONS / 2;
   localparam int POS_WIDTH      = $clog2(DIAL_POSITIONS);

   // Field and state widths
   localparam int TPP_WIDTH   = 12;
   localparam int STEPS_WIDTH = 16;
   localparam int PHASE_WIDTH = 3;
   localparam int COIL_WIDTH  = 4;

   localparam logic [TPP_WIDTH-1:0] TPP_RESET = TPP_WIDTH'(170);

   // Request commands
   localparam logic CMD_MOVE = 1'b0;
   localparam logic CMD_TICK = 1'b1;

   // Phase codes: off, then index of the last energised pattern
   localparam logic [PHASE_WIDTH-1:0] PHASE_OFF   = PHASE_WIDTH'(0);
   localparam logic [PHASE_WIDTH-1:0] PHASE_FIRST = PHASE_WIDTH'(1);
   localparam logic [PHASE_WIDTH-1:0] PHASE_LAST  = PHASE_WIDTH'(4);

   localparam logic [COIL_WIDTH-1:0] COILS_OFF = '0;

   // Full-step coil pattern for a phase; coil one in the top bit
   function automatic logic [COIL_WIDTH-1:0] coil_of(input logic [PHASE_WIDTH-1:0] ph);
      logic [COIL_WIDTH-1:0] pat;
      unique case (ph)
         PHASE_WIDTH'(1): pat = 4'b1010;
         PHASE_WIDTH'(2): pat = 4'b0110;
         PHASE_WIDTH'(3): pat = 4'b0101;
         PHASE_WIDTH'(4): pat = 4'b1001;
         default:         pat = COILS_OFF;
      endcase
      return pat;
   endfunction

endpackage

[hdl/stepper_dial_positioner_core.sv]
// Stepper dial positioner: move/tick request handling and result register.
//
// Usage: each request on the req_ channel is either a move to a dial
// position or one motor tick. Every accepted request produces exactly one
// result on the rsp_ channel: the coil drive pattern after the request,
// the busy flag, the move-done flag and the rejected flag.
// A move while a previous move is still stepping (including its coil-off
// tick) is rejected and changes nothing.
// The result is registered: it is valid in the cycle after the request is accepted.
// Throughput: one request per cycle while each result is taken; the whole update is one pass of
// logic from the state registers into the result register.
// req_ready is high whenever the result register is empty or being taken
// in the same cycle, so a stalled receiver holds at most one result and
// back-pressures the request side only while it stalls.
// Reset (synchronous, active high) clears the result register, puts the
// hand at position 0 with coils off and loads ticks_per_position with 170.
// csr_wr_en writes ticks_per_position; write it only while idle.
module stepper_dial_positioner_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_command,
   input  logic [sdp_pkg::POS_WIDTH-1:0]   req_target_position,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [sdp_pkg::COIL_WIDTH-1:0]  rsp_coil_pattern,
   output logic                            rsp_busy_res,
   output logic                            rsp_move_done,
   output logic                            rsp_rejected,
   input  logic                            csr_wr_en,
   input  logic [sdp_pkg::TPP_WIDTH-1:0]   csr_wr_data
);
   import sdp_pkg::*;

   // Architectural state
   logic [TPP_WIDTH-1:0]   tpp_ff;
   logic [POS_WIDTH-1:0]   hand_ff, hand_in;
   logic [PHASE_WIDTH-1:0] phase_ff, phase_in;
   logic [STEPS_WIDTH-1:0] steps_ff, steps_in;
   logic                   ccw_ff, ccw_in;
   logic                   stop_ff, stop_in;
   logic [COIL_WIDTH-1:0]  coils_ff, coils_in;

   // Result register
   logic                   rsp_valid_ff;
   logic [COIL_WIDTH-1:0]  rsp_coil_ff;
   logic                   rsp_busy_ff;
   logic                   rsp_done_ff, done_in;
   logic                   rsp_rej_ff, rej_in;

   logic                   accept;
   logic                   busy;
   logic [POS_WIDTH-1:0]   target_mod;
   logic [POS_WIDTH:0]     diff_sum;
   logic [POS_WIDTH-1:0]   diff;
   logic [TPP_WIDTH-1:0]   tpp_eff;
   logic [STEPS_WIDTH-1:0] move_steps;
   logic [PHASE_WIDTH-1:0] phase_step;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign busy      = (steps_ff != '0) || stop_ff;

   // Target folded onto the dial, then distance modulo the dial size
   assign target_mod = (req_target_position >= POS_WIDTH'(DIAL_POSITIONS)) ?
                       req_target_position - POS_WIDTH'(DIAL_POSITIONS) :
                       req_target_position;
   always_comb begin
      diff_sum = {1'b0, target_mod} + (POS_WIDTH+1)'(DIAL_POSITIONS) - {1'b0, hand_ff};
      if (diff_sum >= (POS_WIDTH+1)'(DIAL_POSITIONS)) begin
         diff = POS_WIDTH'(diff_sum - (POS_WIDTH+1)'(DIAL_POSITIONS));
      end else begin
         diff = POS_WIDTH'(diff_sum);
      end
   end

   // Step count for a move; a zero setting counts as one
   assign tpp_eff    = (tpp_ff == '0) ? TPP_WIDTH'(1) : tpp_ff;
   assign move_steps = STEPS_WIDTH'(diff) * STEPS_WIDTH'(tpp_eff);

   // Next phase in the full-step sequence
   always_comb begin
      if (phase_ff == PHASE_OFF || phase_ff > PHASE_LAST) begin
         phase_step = PHASE_FIRST;
      end else if (ccw_ff) begin
         phase_step = (phase_ff == PHASE_FIRST) ? PHASE_LAST : phase_ff - PHASE_WIDTH'(1);
      end else begin
         phase_step = (phase_ff == PHASE_LAST) ? PHASE_FIRST : phase_ff + PHASE_WIDTH'(1);
      end
   end

   // Request handling
   always_comb begin
      hand_in  = hand_ff;
      phase_in = phase_ff;
      steps_in = steps_ff;
      ccw_in   = ccw_ff;
      stop_in  = stop_ff;
      coils_in = coils_ff;
      done_in  = 1'b0;
      rej_in   = 1'b0;
      case (req_command)
         CMD_MOVE: begin
            if (busy) begin
               rej_in = 1'b1;
            end else if (diff != '0) begin
               ccw_in   = diff > POS_WIDTH'(HALF_DIAL);
               steps_in = move_steps;
               hand_in  = target_mod;
            end
         end
         default: begin
            if (steps_ff != '0) begin
               phase_in = phase_step;
               coils_in = coil_of(phase_step);
               steps_in = steps_ff - STEPS_WIDTH'(1);
               if (steps_ff == STEPS_WIDTH'(1)) begin
                  stop_in = 1'b1;
               end
            end else if (stop_ff) begin
               stop_in  = 1'b0;
               coils_in = COILS_OFF;
               done_in  = 1'b1;
            end
         end
      endcase
   end

   // Configuration and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tpp_ff   <= TPP_RESET;
         hand_ff  <= '0;
         phase_ff <= PHASE_OFF;
         steps_ff <= '0;
         ccw_ff   <= 1'b0;
         stop_ff  <= 1'b0;
         coils_ff <= COILS_OFF;
      end else begin
         if (csr_wr_en) begin
            tpp_ff <= csr_wr_data;
         end
         if (accept) begin
            hand_ff  <= hand_in;
            phase_ff <= phase_in;
            steps_ff <= steps_in;
            ccw_ff   <= ccw_in;
            stop_ff  <= stop_in;
            coils_ff <= coils_in;
         end
      end
   end

   // Result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_coil_ff <= coils_in;
         rsp_busy_ff <= (steps_in != '0) || stop_in;
         rsp_done_ff <= done_in;
         rsp_rej_ff  <= rej_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_coil_pattern = rsp_coil_ff;
   assign rsp_busy_res     = rsp_busy_ff;
   assign rsp_move_done    = rsp_done_ff;
   assign rsp_rejected     = rsp_rej_ff;

   // Phase never leaves its legal codes
   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_LAST)
      else $error("phase out of range");

   // Coil-off tick only pending once all steps are done
   a_stop_after_steps: assert property (@(posedge clock) disable iff (reset)
      stop_ff |-> steps_ff == '0)
      else $error("stop pending with steps left");

   // Move done reports coils off and idle
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> (rsp_coil_ff == COILS_OFF && !rsp_busy_ff))
      else $error("move done with coils on or busy");

   // A rejected move leaves the block busy
   a_reject_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rej_ff) |-> (rsp_busy_ff && !rsp_done_ff))
      else $error("rejection while idle");

   // Energised coils always show the pattern of the current phase
   a_coils_phase: assert property (@(posedge clock) disable iff (reset)
      (coils_ff != COILS_OFF) |-> coils_ff == coil_of(phase_ff))
      else $error("coil pattern does not match phase");

endmodule
